// ===== sv/tdle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdle_pkg
// shared types and codes of the tree distance engine
// ----------------------------------------------------------------------------
package tdle_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_ANSWER    = 2'd0;
    localparam logic [1:0] ST_BUILT     = 2'd1;
    localparam logic [1:0] ST_DROPPED   = 2'd2;
    localparam logic [1:0] ST_UNREACHED = 2'd3;

    typedef enum logic [5:0] {
        S_RST_SWEEP, S_IDLE, S_DECODE,
        S_ADD_WA, S_ADD_RB, S_ADD_WB, S_CLR,
        S_B_SWEEP, S_B_ROOT, S_B_RTBL, S_B_DONE,
        S_W_POP, S_W_CUR, S_W_HEAD, S_W_EDGE, S_W_TGT, S_W_CHK,
        S_W_LR, S_W_LW, S_W_NX,
        S_Q_RB, S_Q_CHK, S_L1R, S_L1T, S_L1C, S_EQ,
        S_L2R, S_L2Y, S_L2C, S_L0R, S_L0, S_DL, S_DV,
        S_EMIT
    } t_state;

    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_SWEEP_ALL, OP_SWEEP_HEAD, OP_SWEEP_DEPTH, OP_SWEEP_START,
        OP_CLR_EDGES, OP_DROP, OP_ADD_RA, OP_ADD_WA, OP_ADD_RB, OP_ADD_WB,
        OP_ROOT, OP_RTBL, OP_POP, OP_CUR, OP_HEAD, OP_EDGE_RD, OP_TGT, OP_PUSH,
        OP_NEXT_EDGE, OP_LR, OP_LW, OP_RES_BUILD, OP_RES_BAD,
        OP_Q_RA, OP_Q_RB, OP_Q_CHK, OP_L1R, OP_L1T, OP_L1C, OP_EQ,
        OP_L2R, OP_L2Y, OP_L2C, OP_L0R, OP_L0, OP_DL, OP_DV, OP_EMIT
    } t_op;

    typedef struct packed {
        t_cmd cmd;
        logic pair_ok;
        logic store_full;
        logic root_ok;
        logic sweep_last;
        logic queue_empty;
        logic edge_zero;
        logic tgt_new;
        logic level_top;
        logic level_zero;
        logic depth_bad;
        logic pair_same;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== sv/tdle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdle_ctrl
// sequencer for edge store updates, the build walk and lifting queries
// ----------------------------------------------------------------------------
module tdle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  tdle_pkg::t_dp_stat i_stat,
    output tdle_pkg::t_op     o_op
);
    import tdle_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = i_s_valid && o_s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RST_SWEEP: if (i_stat.sweep_last) n_state = S_IDLE;
            S_IDLE:      if (accept) n_state = S_DECODE;
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_ADD: begin
                        if (!i_stat.pair_ok || i_stat.store_full) n_state = S_IDLE;
                        else n_state = S_ADD_WA;
                    end
                    CMD_CLEAR: n_state = S_CLR;
                    CMD_BUILD: n_state = S_B_SWEEP;
                    default: begin
                        if (!i_stat.pair_ok) n_state = S_EMIT;
                        else n_state = S_Q_RB;
                    end
                endcase
            end
            S_ADD_WA:  n_state = S_ADD_RB;
            S_ADD_RB:  n_state = S_ADD_WB;
            S_ADD_WB:  n_state = S_IDLE;
            S_CLR:     if (i_stat.sweep_last) n_state = S_IDLE;
            S_B_SWEEP: begin
                if (i_stat.sweep_last) n_state = i_stat.root_ok ? S_B_ROOT : S_B_DONE;
            end
            S_B_ROOT:  n_state = S_B_RTBL;
            S_B_RTBL:  if (i_stat.level_top) n_state = S_W_POP;
            S_B_DONE:  n_state = S_EMIT;
            S_W_POP:   n_state = i_stat.queue_empty ? S_B_DONE : S_W_CUR;
            S_W_CUR:   n_state = S_W_HEAD;
            S_W_HEAD:  n_state = S_W_EDGE;
            S_W_EDGE:  n_state = i_stat.edge_zero ? S_W_POP : S_W_TGT;
            S_W_TGT:   n_state = S_W_CHK;
            S_W_CHK:   n_state = i_stat.tgt_new ? S_W_LR : S_W_EDGE;
            S_W_LR:    n_state = S_W_LW;
            S_W_LW:    n_state = i_stat.level_top ? S_W_NX : S_W_LR;
            S_W_NX:    n_state = S_W_EDGE;
            S_Q_RB:    n_state = S_Q_CHK;
            S_Q_CHK:   n_state = i_stat.depth_bad ? S_EMIT : S_L1R;
            S_L1R:     n_state = S_L1T;
            S_L1T:     n_state = S_L1C;
            S_L1C:     n_state = i_stat.level_zero ? S_EQ : S_L1R;
            S_EQ:      n_state = i_stat.pair_same ? S_DL : S_L2R;
            S_L2R:     n_state = S_L2Y;
            S_L2Y:     n_state = S_L2C;
            S_L2C:     n_state = i_stat.level_zero ? S_L0R : S_L2R;
            S_L0R:     n_state = S_L0;
            S_L0:      n_state = S_DL;
            S_DL:      n_state = S_DV;
            S_DV:      n_state = S_EMIT;
            S_EMIT:    if (!i_stat.out_busy) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            S_RST_SWEEP: o_op = OP_SWEEP_ALL;
            S_IDLE:      if (accept) o_op = OP_LOAD;
            S_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_ADD: begin
                        if (!i_stat.pair_ok) o_op = OP_NONE;
                        else if (i_stat.store_full) o_op = OP_DROP;
                        else o_op = OP_ADD_RA;
                    end
                    CMD_CLEAR: o_op = OP_CLR_EDGES;
                    CMD_BUILD: o_op = OP_SWEEP_START;
                    default:   o_op = i_stat.pair_ok ? OP_Q_RA : OP_RES_BAD;
                endcase
            end
            S_ADD_WA:  o_op = OP_ADD_WA;
            S_ADD_RB:  o_op = OP_ADD_RB;
            S_ADD_WB:  o_op = OP_ADD_WB;
            S_CLR:     o_op = OP_SWEEP_HEAD;
            S_B_SWEEP: o_op = OP_SWEEP_DEPTH;
            S_B_ROOT:  o_op = OP_ROOT;
            S_B_RTBL:  o_op = OP_RTBL;
            S_B_DONE:  o_op = OP_RES_BUILD;
            S_W_POP:   if (!i_stat.queue_empty) o_op = OP_POP;
            S_W_CUR:   o_op = OP_CUR;
            S_W_HEAD:  o_op = OP_HEAD;
            S_W_EDGE:  if (!i_stat.edge_zero) o_op = OP_EDGE_RD;
            S_W_TGT:   o_op = OP_TGT;
            S_W_CHK:   o_op = i_stat.tgt_new ? OP_PUSH : OP_NEXT_EDGE;
            S_W_LR:    o_op = OP_LR;
            S_W_LW:    o_op = OP_LW;
            S_W_NX:    o_op = OP_NEXT_EDGE;
            S_Q_RB:    o_op = OP_Q_RB;
            S_Q_CHK:   o_op = i_stat.depth_bad ? OP_RES_BAD : OP_Q_CHK;
            S_L1R:     o_op = OP_L1R;
            S_L1T:     o_op = OP_L1T;
            S_L1C:     o_op = OP_L1C;
            S_EQ:      o_op = OP_EQ;
            S_L2R:     o_op = OP_L2R;
            S_L2Y:     o_op = OP_L2Y;
            S_L2C:     o_op = OP_L2C;
            S_L0R:     o_op = OP_L0R;
            S_L0:      o_op = OP_L0;
            S_DL:      o_op = OP_DL;
            S_DV:      o_op = OP_DV;
            S_EMIT:    if (!i_stat.out_busy) o_op = OP_EMIT;
            default:   o_op = OP_NONE;
        endcase
    end

endmodule

// ===== sv/tdle_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdle_dp
// edge store, walk queue, depth, distance and ancestor memories, result regs
// ----------------------------------------------------------------------------
module tdle_dp #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10,
    parameter int WEIGHT_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdle_pkg::t_op      i_op,
    input  logic [1:0]         i_s_user,
    input  logic [27:0]        i_s_data,
    input  logic               i_cfg_valid,
    input  logic [9:0]         i_cfg_data,
    output tdle_pkg::t_dp_stat o_stat,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [31:0]        o_m_data,
    output logic [1:0]         o_m_user
);
    import tdle_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int SLOTS = 2 * MAX_NODES;
    localparam int EW    = $clog2(SLOTS);
    localparam int DW    = EW;
    localparam int LW    = $clog2(LIFT_LEVELS);
    localparam int WB    = (WEIGHT_BITS < 8) ? WEIGHT_BITS : 8;
    localparam int TBL_N = MAX_NODES * (1 << LW);
    localparam logic [DW-1:0] UNR = DW'(SLOTS - 1);

    // input and control registers
    t_cmd            r_cmd;
    logic [9:0]      r_a, r_b, r_root;
    logic [WB-1:0]   r_w, r_len;
    logic [EW-1:0]   r_cnt, r_e, r_nx;
    logic            r_drop;
    logic [NW-1:0]   r_idx, r_cur, r_tgt, r_anc, r_x, r_y, r_t, r_lca;
    logic [NW:0]     r_qhead, r_tail;
    logic [DW-1:0]   r_dcur, r_dy, r_da;
    logic [17:0]     r_distcur, r_sum, r_res_dist;
    logic [LW-1:0]   r_k;
    logic [1:0]      r_res_st, r_ou;
    logic [9:0]      r_res_anc;
    logic [31:0]     r_od;
    logic            r_ov;

    // memories and their read registers
    logic [EW-1:0]   head_mem [MAX_NODES];
    logic [DW-1:0]   dep_mem  [MAX_NODES];
    logic [17:0]     dist_mem [MAX_NODES];
    logic [NW-1:0]   queue_mem[MAX_NODES];
    logic [NW-1:0]   tgt_mem  [SLOTS];
    logic [EW-1:0]   next_mem [SLOTS];
    logic [WB-1:0]   len_mem  [SLOTS];
    logic [NW-1:0]   tbl_mem  [TBL_N];

    logic [EW-1:0]   r_head_q, r_next_q;
    logic [DW-1:0]   r_dep_q;
    logic            r_dep_zero, r_tbl_zero;
    logic [17:0]     r_dist_q;
    logic [NW-1:0]   r_queue_q, r_tgt_q, r_tbl_q;
    logic [WB-1:0]   r_len_q;

    logic            head_we, dep_we, dist_we, queue_we, edge_we, tbl_we;
    logic [NW-1:0]   head_wa, head_ra, dep_wa, dep_ra, dist_wa, dist_ra, queue_wa;
    logic [EW-1:0]   head_wd;
    logic [DW-1:0]   dep_wd;
    logic [17:0]     dist_wd;
    logic [NW-1:0]   queue_wd, edge_tgt_wd, tbl_wd, tbl_node;
    logic [NW+LW-1:0] tbl_wa, tbl_ra;
    logic [LW-1:0]   tbl_lvl;
    logic [EW-1:0]   edge_wa;

    logic [NW-1:0]   a_n, b_n, root_n, tbl_rd;
    logic [DW-1:0]   dep_rd;

    assign a_n    = NW'(r_a);
    assign b_n    = NW'(r_b);
    assign root_n = NW'(r_root);
    assign tbl_rd = r_tbl_zero ? '0 : r_tbl_q;
    assign dep_rd = r_dep_zero ? '0 : r_dep_q;

    always_comb begin
        head_we = 1'b0; head_wa = r_idx; head_wd = '0; head_ra = a_n;
        dep_we = 1'b0; dep_wa = r_idx; dep_wd = UNR; dep_ra = a_n;
        dist_we = 1'b0; dist_wa = root_n; dist_wd = '0; dist_ra = a_n;
        queue_we = 1'b0; queue_wa = r_tail[NW-1:0]; queue_wd = r_tgt;
        edge_we = 1'b0; edge_wa = r_cnt; edge_tgt_wd = b_n;
        tbl_we = 1'b0; tbl_wa = {r_tgt, r_k}; tbl_wd = tbl_rd;
        tbl_node = r_x; tbl_lvl = r_k;
        unique case (i_op) inside
            OP_SWEEP_ALL: begin
                head_we = 1'b1;
                dep_we  = 1'b1;
            end
            OP_SWEEP_HEAD:  head_we = 1'b1;
            OP_SWEEP_DEPTH: dep_we = 1'b1;
            OP_ADD_WA: begin
                head_we = 1'b1; head_wa = a_n; head_wd = r_cnt;
                edge_we = 1'b1;
            end
            OP_ADD_RB: head_ra = b_n;
            OP_ADD_WB: begin
                head_we = 1'b1; head_wa = b_n; head_wd = r_cnt;
                edge_we = 1'b1; edge_tgt_wd = a_n;
            end
            OP_ROOT: begin
                dep_we = 1'b1; dep_wa = root_n; dep_wd = DW'(1);
                dist_we = 1'b1;
                queue_we = 1'b1; queue_wa = '0; queue_wd = root_n;
            end
            OP_RTBL: begin
                tbl_we = 1'b1; tbl_wa = {root_n, r_k}; tbl_wd = '0;
            end
            OP_CUR: begin
                head_ra = r_queue_q; dep_ra = r_queue_q; dist_ra = r_queue_q;
            end
            OP_TGT: dep_ra = r_tgt_q;
            OP_PUSH: begin
                dep_we = 1'b1; dep_wa = r_tgt; dep_wd = r_dcur + DW'(1);
                dist_we = 1'b1; dist_wa = r_tgt; dist_wd = r_distcur + 18'(r_len);
                queue_we = 1'b1;
                tbl_we = 1'b1; tbl_wa = {r_tgt, LW'(0)}; tbl_wd = r_cur;
            end
            OP_LR: begin
                tbl_node = r_anc; tbl_lvl = r_k - LW'(1);
            end
            OP_LW:  tbl_we = 1'b1;
            OP_Q_RB: begin
                dep_ra = b_n; dist_ra = b_n;
            end
            OP_L1T: dep_ra = tbl_rd;
            OP_L2Y: tbl_node = r_y;
            OP_L0R: tbl_lvl = '0;
            OP_DL:  dist_ra = r_lca;
            default: ;
        endcase
    end

    assign tbl_ra = {tbl_node, tbl_lvl};

    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        r_head_q <= head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) dep_mem[dep_wa] <= dep_wd;
        r_dep_q    <= dep_mem[dep_ra];
        r_dep_zero <= (dep_ra == '0);
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) dist_mem[dist_wa] <= dist_wd;
        r_dist_q <= dist_mem[dist_ra];
    end

    always_ff @(posedge i_clk) begin
        if (queue_we) queue_mem[queue_wa] <= queue_wd;
        r_queue_q <= queue_mem[r_qhead[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            tgt_mem[edge_wa]  <= edge_tgt_wd;
            next_mem[edge_wa] <= r_head_q;
            len_mem[edge_wa]  <= r_w;
        end
        r_tgt_q  <= tgt_mem[r_e];
        r_next_q <= next_mem[r_e];
        r_len_q  <= len_mem[r_e];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
        r_tbl_q    <= tbl_mem[tbl_ra];
        r_tbl_zero <= (tbl_node == '0);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= 10'd1;
            r_idx  <= '0;
            r_cnt  <= EW'(1);
            r_drop <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_root <= i_cfg_data;
            if (r_ov && i_m_ready) r_ov <= 1'b0;
            unique case (i_op) inside
                OP_SWEEP_ALL, OP_SWEEP_HEAD, OP_SWEEP_DEPTH: r_idx <= r_idx + NW'(1);
                OP_SWEEP_START: r_idx <= '0;
                OP_CLR_EDGES: begin
                    r_idx  <= '0;
                    r_cnt  <= EW'(1);
                    r_drop <= 1'b0;
                end
                OP_DROP:              r_drop <= 1'b1;
                OP_ADD_WA, OP_ADD_WB: r_cnt <= r_cnt + EW'(1);
                OP_EMIT:              r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_op) inside
            OP_LOAD: begin
                r_cmd <= t_cmd'(i_s_user);
                r_a   <= i_s_data[9:0];
                r_b   <= i_s_data[19:10];
                r_w   <= i_s_data[20 +: WB];
            end
            OP_ROOT: begin
                r_qhead <= '0;
                r_tail  <= (NW+1)'(1);
                r_k     <= '0;
            end
            OP_RTBL: r_k <= r_k + LW'(1);
            OP_POP:  r_qhead <= r_qhead + (NW+1)'(1);
            OP_CUR:  r_cur <= r_queue_q;
            OP_HEAD: begin
                r_e       <= r_head_q;
                r_dcur    <= dep_rd;
                r_distcur <= r_dist_q;
            end
            OP_TGT: begin
                r_tgt <= r_tgt_q;
                r_nx  <= r_next_q;
                r_len <= r_len_q;
            end
            OP_PUSH: begin
                r_tail <= r_tail + (NW+1)'(1);
                r_k    <= LW'(1);
                r_anc  <= r_cur;
            end
            OP_NEXT_EDGE: r_e <= r_nx;
            OP_LW: begin
                r_anc <= tbl_rd;
                r_k   <= r_k + LW'(1);
            end
            OP_RES_BUILD: begin
                r_res_st   <= r_drop ? ST_DROPPED : ST_BUILT;
                r_res_dist <= '0;
                r_res_anc  <= '0;
            end
            OP_RES_BAD: begin
                r_res_st   <= ST_UNREACHED;
                r_res_dist <= '0;
                r_res_anc  <= '0;
            end
            OP_Q_RB: begin
                r_da  <= dep_rd;
                r_sum <= r_dist_q;
            end
            OP_Q_CHK: begin
                r_sum <= r_sum + r_dist_q;
                r_k   <= LW'(LIFT_LEVELS - 1);
                if (r_da < dep_rd) begin
                    r_x  <= b_n;
                    r_y  <= a_n;
                    r_dy <= r_da;
                end else begin
                    r_x  <= a_n;
                    r_y  <= b_n;
                    r_dy <= dep_rd;
                end
            end
            OP_L1T, OP_L2Y: r_t <= tbl_rd;
            OP_L1C: begin
                if (dep_rd >= r_dy) r_x <= r_t;
                r_k <= r_k - LW'(1);
            end
            OP_EQ: begin
                r_k   <= LW'(LIFT_LEVELS - 1);
                r_lca <= r_x;
            end
            OP_L2C: begin
                if (r_t != tbl_rd) begin
                    r_x <= r_t;
                    r_y <= tbl_rd;
                end
                r_k <= r_k - LW'(1);
            end
            OP_L0: r_lca <= tbl_rd;
            OP_DV: begin
                r_res_st   <= ST_ANSWER;
                r_res_dist <= r_sum - {r_dist_q[16:0], 1'b0};
                r_res_anc  <= 10'(r_lca);
            end
            OP_EMIT: begin
                r_od <= {4'd0, r_res_anc, r_res_dist};
                r_ou <= r_res_st;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.pair_ok     = (r_a != '0) && (32'(r_a) < 32'(MAX_NODES))
                          && (r_b != '0) && (32'(r_b) < 32'(MAX_NODES));
        o_stat.store_full  = (32'(r_cnt) + 32'd2) > 32'(SLOTS);
        o_stat.root_ok     = (r_root != '0) && (32'(r_root) < 32'(MAX_NODES));
        o_stat.sweep_last  = (r_idx == NW'(MAX_NODES - 1));
        o_stat.queue_empty = (r_qhead == r_tail);
        o_stat.edge_zero   = (r_e == '0);
        o_stat.tgt_new     = (dep_rd > (r_dcur + DW'(1)))
                          && (32'(r_tail) < 32'(MAX_NODES));
        o_stat.level_top   = (r_k == LW'(LIFT_LEVELS - 1));
        o_stat.level_zero  = (r_k == '0);
        o_stat.depth_bad   = (r_da == UNR) || (dep_rd == UNR);
        o_stat.pair_same   = (r_x == r_y);
        o_stat.out_busy    = r_ov;
    end

    assign o_m_valid = r_ov;
    assign o_m_data  = r_od;
    assign o_m_user  = r_ou;

endmodule

// ===== sv/tree_distance_lca_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_distance_lca_engine_top
// weighted tree distance with lowest common ancestor by binary lifting
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid / tready       tuser command, tdata node_a node_b weight
//  m_axis    out  tvalid / tready       tuser status, tdata distance ancestor
//  cfg       in   valid / ready         root_node
//
//  clear sweeps the adjacency heads; queries use the single ancestor table port
//  build sweeps the depths, writes the root and its table rows, then walks each
//  queued node's edge list and fills the lifting rows of every new node
//  after reset a sweep of heads and depths runs, no items taken
//  a result held on m_axis does not stop the next item from entering
// ----------------------------------------------------------------------------
module tree_distance_lca_engine_top #(
    parameter int MAX_NODES   = 1024,
    parameter int LIFT_LEVELS = 10,
    parameter int WEIGHT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // node_a, node_b, weight, pad
    input  logic [1:0]  i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // distance, ancestor, pad
    output logic [1:0]  o_m_axis_tuser,  // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data       // root_node
);
    import tdle_pkg::*;

    t_op      op;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    tdle_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_stat    (stat),
        .o_op      (op)
    );

    tdle_dp #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_s_user    (i_s_axis_tuser),
        .i_s_data    (i_s_axis_tdata[27:0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_user    (o_m_axis_tuser)
    );

endmodule

// ===== tb/tdle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdle_checker
// watches the item, result and root channels of the tree distance engine,
// keeps its own edge store and lifting tables, and compares every result beat
// ----------------------------------------------------------------------------
module tdle_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_dropped_builds
);
    import tdle_pkg::*;

    localparam int NODES  = 1024;
    localparam int LEVELS = 10;
    localparam int SLOTS  = 2 * NODES;
    localparam logic [10:0] UNREACH = 11'(SLOTS - 1);

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] distance;
        logic [9:0]  ancestor;
    } t_answer;

    logic [9:0]  root_reg;
    logic [10:0] list_head [NODES];
    logic [10:0] link_next [SLOTS];
    logic [9:0]  link_node [SLOTS];
    logic [7:0]  link_len  [SLOTS];
    logic [11:0] free_slot;
    logic        store_lost;
    logic [10:0] depth_of  [NODES];
    logic [17:0] dist_of   [NODES];
    logic [9:0]  up_of     [NODES][LEVELS];
    logic [9:0]  bfs_order [NODES];

    t_answer answers_due[$];

    function automatic bit node_valid(logic [9:0] n);
        return n != 10'd0;
    endfunction

    function automatic void link_push(logic [9:0] from, logic [9:0] to, logic [7:0] len);
        link_node[free_slot] = to;
        link_next[free_slot] = list_head[from];
        link_len[free_slot]  = len;
        list_head[from]      = free_slot[10:0];
        free_slot++;
    endfunction

    function automatic void lift_tables();
        int          rd, wr;
        logic [9:0]  cur, nxt;
        logic [10:0] e;
        for (int i = 0; i < NODES; i++) begin
            depth_of[i] = UNREACH;
            dist_of[i]  = '0;
            for (int k = 0; k < LEVELS; k++) up_of[i][k] = '0;
        end
        depth_of[0] = '0;
        if (!node_valid(root_reg)) return;
        depth_of[root_reg] = 11'd1;
        rd = 0;
        wr = 0;
        bfs_order[wr++] = root_reg;
        while (rd < wr) begin
            cur = bfs_order[rd++];
            e = list_head[cur];
            while (e != 0) begin
                nxt = link_node[e];
                if (depth_of[nxt] > depth_of[cur] + 11'd1 && wr < NODES) begin
                    depth_of[nxt] = depth_of[cur] + 11'd1;
                    bfs_order[wr++] = nxt;
                    dist_of[nxt] = dist_of[cur] + 18'(link_len[e]);
                    up_of[nxt][0] = cur;
                    for (int k = 1; k < LEVELS; k++)
                        up_of[nxt][k] = up_of[up_of[nxt][k-1]][k-1];
                end
                e = link_next[e];
            end
        end
    endfunction

    function automatic logic [9:0] meet_node(logic [9:0] x, logic [9:0] y);
        logic [9:0] t;
        if (depth_of[x] < depth_of[y]) begin
            t = x; x = y; y = t;
        end
        for (int k = LEVELS - 1; k >= 0; k--)
            if (depth_of[up_of[x][k]] >= depth_of[y]) x = up_of[x][k];
        if (x == y) return x;
        for (int k = LEVELS - 1; k >= 0; k--)
            if (up_of[x][k] != up_of[y][k]) begin
                x = up_of[x][k];
                y = up_of[y][k];
            end
        return up_of[x][0];
    endfunction

    function automatic void apply_item(t_cmd cmd, logic [9:0] a, logic [9:0] b,
                                       logic [7:0] w);
        t_answer    ans;
        logic [9:0] m;
        ans = '0;
        case (cmd)
            CMD_ADD: begin
                if (node_valid(a) && node_valid(b)) begin
                    if (free_slot + 12'd2 > 12'(SLOTS)) store_lost = 1'b1;
                    else begin
                        link_push(a, b, w);
                        link_push(b, a, w);
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < NODES; i++) list_head[i] = '0;
                free_slot  = 12'd1;
                store_lost = 1'b0;
            end
            CMD_BUILD: begin
                lift_tables();
                ans.status = store_lost ? ST_DROPPED : ST_BUILT;
                answers_due.push_back(ans);
            end
            default: begin
                if (!node_valid(a) || !node_valid(b) || depth_of[a] == UNREACH ||
                        depth_of[b] == UNREACH) begin
                    ans.status = ST_UNREACHED;
                end else begin
                    m = meet_node(a, b);
                    ans.status   = ST_ANSWER;
                    ans.ancestor = m;
                    ans.distance = dist_of[a] + dist_of[b] - 18'(2 * dist_of[m]);
                end
                answers_due.push_back(ans);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            root_reg   = 10'd1;
            free_slot  = 12'd1;
            store_lost = 1'b0;
            for (int i = 0; i < NODES; i++) begin
                list_head[i] = '0;
                depth_of[i]  = UNREACH;
                dist_of[i]   = '0;
                for (int k = 0; k < LEVELS; k++) up_of[i][k] = '0;
            end
            answers_due.delete();
            o_fail_count     = 0;
            o_result_count   = 0;
            o_dropped_builds = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) root_reg = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                apply_item(t_cmd'(i_s_tuser), i_s_tdata[9:0], i_s_tdata[19:10],
                           i_s_tdata[27:20]);
            if (i_m_tvalid && i_m_tready) begin
                got.status   = i_m_tuser;
                got.distance = i_m_tdata[17:0];
                got.ancestor = i_m_tdata[27:18];
                o_result_count++;
                if (got.status == ST_DROPPED) o_dropped_builds++;
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result beat status %0d dist %0d anc %0d",
                             $time, got.status, got.distance, got.ancestor);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.distance != want.distance) begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, want.distance, got.distance);
                        o_fail_count++;
                    end
                    if (got.ancestor != want.ancestor) begin
                        $display("%0t: ancestor expected %0d actual %0d",
                                 $time, want.ancestor, got.ancestor);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives edge, build, query and clear beats plus root writes into the tree
// distance engine under random idling; results are checked by tdle_checker
// ----------------------------------------------------------------------------
module tb;
    import tdle_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [9:0]  cfg_data;

    int fail_count, pending, result_count, dropped_builds;
    int send_idle, recv_idle;
    int hold_ask, hold_seen, hold_left;
    int n_items, n_builds, n_queries, n_roots;
    logic [9:0] root_now;
    logic [9:0] members [64];
    bit         taken [1024];

    tree_distance_lca_engine_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    tdle_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_dropped_builds(dropped_builds)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // result side ready, with long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = 5000;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic update_idling();
        if (n_items < 250) begin
            send_idle = 18;
            recv_idle = 69;
        end else if (n_items < 500) begin
            send_idle = 69;
            recv_idle = 18;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send_beat(t_cmd cmd, logic [9:0] a, logic [9:0] b, logic [7:0] w);
        bit ok;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, w, b, a};
        do begin
            @(negedge i_clk);
            ok = s_tready;
            @(posedge i_clk);
        end while (!ok);
        n_items++;
        if (cmd == CMD_BUILD) n_builds++;
        if (cmd == CMD_QUERY) n_queries++;
        update_idling();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_root(logic [9:0] r);
        bit ok;
        drain();
        repeat (1200) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do begin
            @(negedge i_clk);
            ok = cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        cfg_valid <= 1'b0;
        root_now = r;
        n_roots++;
    endtask

    function automatic logic [7:0] pick_weight();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // random tree on fresh nodes hung from the current root, then queries
    task automatic tree_episode(int size);
        logic [9:0] n;
        int         p;
        for (int i = 0; i < 1024; i++) taken[i] = 1'b0;
        members[0] = root_now;
        taken[root_now] = 1'b1;
        for (int i = 1; i < size; i++) begin
            do n = 10'($urandom_range(1, 1023)); while (taken[n]);
            taken[n] = 1'b1;
            members[i] = n;
        end
        send_beat(CMD_CLEAR, 10'($urandom), 10'($urandom), 8'($urandom));
        if ($urandom_range(3) == 0)
            send_beat(CMD_QUERY, members[0], members[$urandom_range(size - 1)], 8'd0);
        for (int i = 1; i < size; i++) begin
            p = $urandom_range(i - 1);
            if ($urandom_range(1)) send_beat(CMD_ADD, members[p], members[i], pick_weight());
            else send_beat(CMD_ADD, members[i], members[p], pick_weight());
            if ($urandom_range(15) == 0)
                send_beat(CMD_ADD, members[$urandom_range(i)], members[$urandom_range(i)],
                          pick_weight());
            if ($urandom_range(31) == 0)
                send_beat(CMD_ADD, 10'd0, members[i], pick_weight());
        end
        send_beat(CMD_BUILD, 10'($urandom), 10'($urandom), 8'($urandom));
        repeat ($urandom_range(8, 25)) begin
            if ($urandom_range(9) == 0)
                send_beat(CMD_QUERY, 10'($urandom), members[$urandom_range(size - 1)],
                          8'($urandom));
            else
                send_beat(CMD_QUERY, members[$urandom_range(size - 1)],
                          members[$urandom_range(size - 1)], 8'($urandom));
        end
    endtask

    initial begin
        int episode;
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_ADD;
        cfg_valid = 1'b0;
        cfg_data  = 10'd1;
        hold_ask  = 0;
        n_items = 0; n_builds = 0; n_queries = 0; n_roots = 0;
        root_now = 10'd1;
        update_idling();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: before any build, small graph, ignored edges, stale tables
        send_beat(CMD_QUERY, 10'd1, 10'd1, 8'd0);
        send_beat(CMD_ADD, 10'd1, 10'd1023, 8'd255);
        send_beat(CMD_ADD, 10'd1023, 10'd2, 8'd0);
        send_beat(CMD_ADD, 10'd0, 10'd5, 8'd7);
        send_beat(CMD_ADD, 10'd5, 10'd0, 8'd7);
        send_beat(CMD_ADD, 10'd2, 10'd682, 8'd170);
        send_beat(CMD_ADD, 10'd2, 10'd1, 8'd85);
        send_beat(CMD_BUILD, 10'd0, 10'd0, 8'd0);
        send_beat(CMD_QUERY, 10'd1, 10'd2, 8'd0);
        send_beat(CMD_QUERY, 10'd2, 10'd2, 8'd0);
        send_beat(CMD_QUERY, 10'd682, 10'd1023, 8'd0);
        send_beat(CMD_QUERY, 10'd0, 10'd1, 8'd0);
        send_beat(CMD_QUERY, 10'd341, 10'd2, 8'd0);
        send_beat(CMD_QUERY, 10'd1023, 10'd682, 8'hff);
        send_beat(CMD_CLEAR, 10'd0, 10'd0, 8'd0);
        send_beat(CMD_QUERY, 10'd1, 10'd682, 8'd0);
        send_beat(CMD_BUILD, 10'd0, 10'd0, 8'd0);
        send_beat(CMD_QUERY, 10'd1, 10'd1, 8'd0);
        send_beat(CMD_QUERY, 10'd1, 10'd2, 8'd0);
        write_root(10'd0);
        send_beat(CMD_BUILD, 10'd0, 10'd0, 8'd0);
        send_beat(CMD_QUERY, 10'd1, 10'd1, 8'd0);
        write_root(10'd1023);
        tree_episode(6);

        // full edge store: one long chain, the last edge is lost
        write_root(10'd1);
        send_beat(CMD_CLEAR, 10'd0, 10'd0, 8'd0);
        for (int i = 1; i < 1023; i++)
            send_beat(CMD_ADD, 10'(i), 10'(i + 1), pick_weight());
        send_beat(CMD_ADD, 10'd1023, 10'd500, 8'd1);
        send_beat(CMD_ADD, 10'd3, 10'd900, 8'd1);
        send_beat(CMD_BUILD, 10'd0, 10'd0, 8'd0);
        send_beat(CMD_QUERY, 10'd1023, 10'd1, 8'd0);
        repeat (10) send_beat(CMD_QUERY, 10'($urandom_range(1, 1023)),
                              10'($urandom_range(1, 1023)), 8'd0);
        send_beat(CMD_CLEAR, 10'd0, 10'd0, 8'd0);
        n_items = 0;
        update_idling();

        episode = 0;
        while (n_items < 750) begin
            if (episode % 4 == 3) begin
                case ($urandom_range(2))
                    0: write_root(10'd1);
                    1: write_root(10'd1023);
                    default: write_root(10'($urandom_range(1, 1023)));
                endcase
            end
            if (episode == 5) begin
                hold_ask++;
                tree_episode(40);
            end else if (episode == 9) begin
                drain();
                tree_episode($urandom_range(2, 30));
            end else begin
                tree_episode(($urandom_range(4) == 0) ? 60 : $urandom_range(2, 16));
            end
            episode++;
        end

        drain();
        repeat (1200) @(posedge i_clk);
        $display("covered %0d items after the directed part, %0d builds, %0d queries",
                 n_items, n_builds, n_queries);
        $display("%0d result beats checked, %0d with lost edges, %0d root writes",
                 result_count, dropped_builds, n_roots);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
